FILE: sv/isep_pkg.sv
// ----------------------------------------------------------------------------
// isep_pkg
// Shared types and constants for the indexed stack engine.
// ----------------------------------------------------------------------------
package isep_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the command and response items
    localparam int CMD_W      = 2;
    localparam int POS_W      = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_ADDED_TO_END = 3'd1,
        ST_OUT_OF_BORDER = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

endpackage

FILE: sv/ise_if.sv
// ----------------------------------------------------------------------------
// ise_cmd_if / ise_rsp_if
// Valid/ready channels carrying command items and response items.
// ----------------------------------------------------------------------------
interface ise_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [isep_pkg::CMD_W-1:0]     cmd;
    logic signed [isep_pkg::POS_W-1:0] position;
    logic [isep_pkg::IN_DATA_W-1:0] entry_data;

    modport source (output valid, output cmd, output position, output entry_data,
                    input ready);
    modport sink   (input valid, input cmd, input position, input entry_data,
                    output ready);
endinterface

interface ise_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [isep_pkg::OUT_DATA_W-1:0] read_data;
    logic [isep_pkg::STATUS_W-1:0]   status;
    logic [isep_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

FILE: sv/indexed_stack_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_stack_engine_unit
// Bounded stack with insert, remove and read at a position counted from the
// top, plus clear. Entries live in a register array that shifts in parallel.
// ----------------------------------------------------------------------------
//  channel | dir | fields                             | item
//  i_cmd   | in  | cmd, position, entry_data          | one command
//  o_rsp   | out | read_data, status, entry_count     | one response per command
//
//  One item per cycle sustained while o_rsp.ready holds; each command
//  passes the command register, then the response register. Per item, the
//  fill count is compared and insert/remove shift the entry array in parallel.
//  Reset clears the fill count and both valid flags; entry contents are
//  left as they are and are never read before being written.
//  A stalled response holds in its register; the command register holds
//  behind it, and i_cmd.ready drops only when both are full.
// ----------------------------------------------------------------------------
module indexed_stack_engine_unit #(
    parameter int DEPTH      = isep_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = isep_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ise_cmd_if.sink     i_cmd,
    ise_rsp_if.source   o_rsp
);
    import isep_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W = (DATA_WIDTH > IN_DATA_W) ? DATA_WIDTH : IN_DATA_W;
    localparam int CE_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // command register
    logic                  r_s1_valid;
    t_cmd                  r_s1_cmd;
    logic [POS_W-1:0]      r_s1_pos;
    logic [DATA_WIDTH-1:0] r_s1_data;

    // stack state
    logic [DATA_WIDTH-1:0] r_store [DEPTH];
    logic [DATA_WIDTH-1:0] n_store [DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    // response register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_status               r_out_status;
    logic [COUNT_W-1:0]    r_out_count;

    t_status               n_status;
    logic [DATA_WIDTH-1:0] n_rd;

    logic                  w_adv;
    logic                  w_fire;
    logic                  w_neg;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_at;
    logic [DATA_WIDTH-1:0] w_rd_word;
    logic [EXT_W-1:0]      w_in_ext;
    logic [EXT_W-1:0]      w_rd_ext;
    logic [CE_W-1:0]       w_cnt_ext;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_s1_valid && w_adv;
    assign i_cmd.ready = !r_s1_valid || w_adv;

    assign w_neg     = r_s1_pos[POS_W-1];
    assign w_pos     = CMP_W'(r_s1_pos);
    assign w_cnt     = CMP_W'(r_count);
    assign w_at      = (w_pos > w_cnt) ? w_cnt : w_pos;
    assign w_rd_word = r_store[r_s1_pos[IDX_W-1:0]];
    assign w_in_ext  = EXT_W'(i_cmd.entry_data);
    assign w_rd_ext  = EXT_W'(n_rd);
    assign w_cnt_ext = CE_W'(n_count);

    always_comb begin
        n_store  = r_store;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        if (r_s1_cmd == CMD_CLEAR) begin
            n_count = '0;
        end else if (w_neg) begin
            n_status = ST_OUT_OF_BORDER;
        end else begin
            case (r_s1_cmd)
                CMD_INSERT: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        if (w_pos > w_cnt) begin
                            n_status = ST_ADDED_TO_END;
                        end
                        // push entries at and below the insert point down one
                        if (w_at == '0) begin
                            n_store[0] = r_s1_data;
                        end
                        for (int i = 1; i < DEPTH; i++) begin
                            if (CMP_W'(i) == w_at) begin
                                n_store[i] = r_s1_data;
                            end else if (CMP_W'(i) > w_at) begin
                                n_store[i] = r_store[i-1];
                            end
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_REMOVE, CMD_READ: begin
                    if (r_count == '0 && w_pos == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_pos >= w_cnt) begin
                        n_status = ST_OUT_OF_BORDER;
                    end else begin
                        n_rd = w_rd_word;
                        if (r_s1_cmd == CMD_REMOVE) begin
                            // pull entries below the removal point up one
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                if (CMP_W'(i) >= w_pos) begin
                                    n_store[i] = r_store[i+1];
                                end
                            end
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s1_cmd  <= t_cmd'(i_cmd.cmd);
            r_s1_pos  <= i_cmd.position;
            r_s1_data <= w_in_ext[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data   <= w_rd_ext[OUT_DATA_W-1:0];
            r_out_status <= n_status;
            r_out_count  <= w_cnt_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_data;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

endmodule

FILE: sv/ise_chk.sv
// ----------------------------------------------------------------------------
// ise_chk
// Port-level checks for the indexed stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module ise_chk #(
    parameter int DEPTH = isep_pkg::DEPTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [isep_pkg::OUT_DATA_W-1:0] i_rsp_data,
    input logic [isep_pkg::STATUS_W-1:0]   i_rsp_status,
    input logic [isep_pkg::COUNT_W-1:0]    i_rsp_count
);
    import isep_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_CNT = DEPTH[COUNT_W-1:0];

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data)
            && $stable(i_rsp_status) && $stable(i_rsp_count))
        else $error("response changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_data == '0)
        else $error("nonzero data on a failed command");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL |-> i_rsp_count == FULL_CNT)
        else $error("full reported with a count below depth");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY |-> i_rsp_count == '0)
        else $error("empty reported with entries held");

endmodule

bind indexed_stack_engine_unit ise_chk #(.DEPTH(DEPTH)) u_ise_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.read_data),
    .i_rsp_status (o_rsp.status),
    .i_rsp_count  (o_rsp.entry_count)
);
